/* src/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Types, constants and helpers shared by the nearest palette colour search.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int COMPONENT_BITS = 8;
   localparam int COMP_W         = 8;
   localparam int INDEX_W        = 8;
   localparam int DIST_W         = 18;
   localparam int SQ_W           = 2 * COMP_W;
   localparam int SIX_BIT_SHIFT  = 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [COMP_W-1:0] COMP_MASK     = COMP_W'((1 << COMPONENT_BITS) - 1);
   localparam logic [COMP_W-1:0] SIX_BIT_LIMIT = COMP_W'(63);
   localparam logic [DIST_W-1:0] MAX_DIST      = DIST_W'(195075);

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef logic [COMP_W-1:0] comp_type;

   typedef struct packed {
      logic                 action;
      logic [INDEX_W-1:0]   entry_index;
      comp_type             red;
      comp_type             green;
      comp_type             blue;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]   best_index;
      comp_type             match_red;
      comp_type             match_green;
      comp_type             match_blue;
      logic [DIST_W-1:0]    match_distance;
   } rsp_type;

   // Classified command passed from the front end to the search engine
   typedef struct packed {
      logic                 is_query;
      logic                 in_range;
      logic [INDEX_W-1:0]   index;
      comp_type             red;
      comp_type             green;
      comp_type             blue;
   } cmd_type;

   function automatic logic [SQ_W-1:0] sq_diff(input comp_type a, input comp_type b);
      comp_type d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   function automatic comp_type six_bit_scale(input comp_type x);
      return comp_type'((x << SIX_BIT_SHIFT) & COMP_MASK);
   endfunction

endpackage

/* src/nearest_palette_color_search_core.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search_core
// Palette of RGB entries with a nearest colour search by squared distance.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload            | Handshake
//  --------+-----------+--------------------+----------------------
//  req     | in        | nps_pkg::req_type  | req_valid / req_ready
//  rsp     | out       | nps_pkg::rsp_type  | rsp_valid / rsp_ready
//
//  Engine: a load is written while the search engine stays idle. A query
//  walks the palette RAM one entry per cycle through its single read port,
//  then drains the compare pipeline; commands reach the engine through the
//  input register and the command queue.
//  Reset: synchronous, active high; clears control state and the largest
//  component tracker. The palette RAM is not cleared.
//  Stalls: a result waits in the output register while the next commands
//  are queued and loads keep executing; a finished query holds in the
//  engine only if the output register is still occupied.
//
module nearest_palette_color_search_core #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nps_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   // front end -> queue
   logic             f_valid, f_ready;
   nps_pkg::cmd_type f_cmd;

   // queue -> search engine
   logic             q_valid, q_ready;
   nps_pkg::cmd_type q_cmd;

   // Classifies each transaction and flags loads beyond the palette
   nps_front #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .cmd_valid(f_valid),
      .cmd_ready(f_ready),
      .cmd_data (f_cmd)
   );

   // Decouples intake from the long query sweep
   nps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data (f_cmd),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_data  (q_cmd)
   );

   // Executes commands in order: palette writes and nearest-entry sweeps
   nps_back #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES),
      .IDX_W          (IDX_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(q_valid),
      .cmd_ready(q_ready),
      .cmd_data (q_cmd),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

/* src/nps_ram.sv */
// ----------------------------------------------------------------------------
// nps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nps_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/nps_front.sv */
// ----------------------------------------------------------------------------
// nps_front
// Input stage: registers each transaction, masks components, flags range.
// ----------------------------------------------------------------------------
module nps_front #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nps_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output nps_pkg::cmd_type cmd_data
);

   logic             vld_ff, vld_in;
   nps_pkg::cmd_type cmd_ff, cmd_in;
   logic             take;

   assign req_ready = !vld_ff || cmd_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      cmd_in.is_query = (req_data.action == nps_pkg::ACT_QUERY);
      cmd_in.in_range = (32'(req_data.entry_index) < PALETTE_ENTRIES);
      cmd_in.index    = req_data.entry_index;
      cmd_in.red      = req_data.red   & nps_pkg::COMP_MASK;
      cmd_in.green    = req_data.green & nps_pkg::COMP_MASK;
      cmd_in.blue     = req_data.blue  & nps_pkg::COMP_MASK;
      vld_in          = take || (vld_ff && !cmd_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = vld_ff;
   assign cmd_data  = cmd_ff;

endmodule

/* src/nps_queue.sv */
// ----------------------------------------------------------------------------
// nps_queue
// Short command FIFO between front end and search engine.
// ----------------------------------------------------------------------------
module nps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  nps_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output nps_pkg::cmd_type pop_data
);

   localparam int PTR_W = $clog2(nps_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(nps_pkg::QUEUE_DEPTH + 1);

   nps_pkg::cmd_type   slot_ff [nps_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(nps_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/nps_back.sv */
// ----------------------------------------------------------------------------
// nps_back
// Search engine: palette writes, component tracking and the nearest sweep.
// ----------------------------------------------------------------------------
module nps_back #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int IDX_W           = $clog2(PALETTE_ENTRIES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  nps_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nps_pkg::rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam int               ENTRY_W = 3 * nps_pkg::COMP_W;
   localparam logic [IDX_W-1:0] LAST    = IDX_W'(PALETTE_ENTRIES - 1);

   logic [1:0]              state_ff, state_in;
   nps_pkg::comp_type       max_ff, max_in;
   nps_pkg::cmd_type        query_ff, query_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;

   logic                    s1_vld_ff, s1_vld_in;
   logic                    s1_last_ff, s1_last_in;
   logic [IDX_W-1:0]        s1_idx_ff, s1_idx_in;

   logic                    s2_vld_ff, s2_vld_in;
   logic                    s2_last_ff, s2_last_in;
   logic [IDX_W-1:0]        s2_idx_ff, s2_idx_in;
   logic [nps_pkg::SQ_W-1:0] s2_sq_ff [3];
   logic [nps_pkg::SQ_W-1:0] s2_sq_in [3];
   nps_pkg::comp_type       s2_e_ff [3];
   nps_pkg::comp_type       s2_e_in [3];

   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [nps_pkg::DIST_W-1:0] best_d_ff, best_d_in;
   nps_pkg::comp_type        best_c_ff [3];
   nps_pkg::comp_type        best_c_in [3];

   logic                    rsp_vld_ff, rsp_vld_in;
   nps_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    pop, wr_en, six, take, out_free;
   logic [ENTRY_W-1:0]      rd_data;
   nps_pkg::comp_type       raw [3];
   nps_pkg::comp_type       qcol [3];
   nps_pkg::comp_type       m;
   logic [nps_pkg::DIST_W-1:0] dist_sum;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign pop       = cmd_valid && cmd_ready;
   assign wr_en     = pop && !cmd_data.is_query && cmd_data.in_range;
   assign six       = (max_ff <= nps_pkg::SIX_BIT_LIMIT);
   assign out_free  = !rsp_vld_ff || rsp_ready;

   nps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PALETTE_ENTRIES),
      .ADDR_W(IDX_W)
   ) u_palette (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(IDX_W'(cmd_data.index)),
      .wr_data({cmd_data.red, cmd_data.green, cmd_data.blue}),
      .rd_en  (state_ff == ST_SWEEP),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   // Load path: tracker restarts on a write to slot zero
   always_comb begin
      m = (cmd_data.index == '0) ? '0 : max_ff;
      if (cmd_data.red   > m) m = cmd_data.red;
      if (cmd_data.green > m) m = cmd_data.green;
      if (cmd_data.blue  > m) m = cmd_data.blue;
      max_in = wr_en ? m : max_ff;
   end

   // Sequencer and read issue
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      query_in   = query_ff;
      s1_vld_in  = (state_ff == ST_SWEEP);
      s1_last_in = (addr_ff == LAST);
      s1_idx_in  = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop && cmd_data.is_query) begin
               query_in = cmd_data;
               addr_in  = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            addr_in = addr_ff + IDX_W'(1);
            if (addr_ff == LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_vld_ff && s2_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Stage 2: scale entry and square the differences
   always_comb begin
      raw[0]     = rd_data[3*nps_pkg::COMP_W-1:2*nps_pkg::COMP_W];
      raw[1]     = rd_data[2*nps_pkg::COMP_W-1:nps_pkg::COMP_W];
      raw[2]     = rd_data[nps_pkg::COMP_W-1:0];
      qcol[0]    = query_ff.red;
      qcol[1]    = query_ff.green;
      qcol[2]    = query_ff.blue;
      s2_vld_in  = s1_vld_ff;
      s2_last_in = s1_last_ff;
      s2_idx_in  = s1_idx_ff;
      for (int c = 0; c < 3; c++) begin
         s2_e_in[c]  = six ? nps_pkg::six_bit_scale(raw[c]) : raw[c];
         s2_sq_in[c] = nps_pkg::sq_diff(s2_e_in[c], qcol[c]);
      end
   end

   // Stage 3: sum and keep the strictly smaller distance
   always_comb begin
      dist_sum = nps_pkg::DIST_W'(s2_sq_ff[0]) + nps_pkg::DIST_W'(s2_sq_ff[1])
               + nps_pkg::DIST_W'(s2_sq_ff[2]);
      take = s2_vld_ff && ((s2_idx_ff == '0) || (dist_sum < best_d_ff));
      best_idx_in = take ? s2_idx_ff : best_idx_ff;
      best_d_in   = take ? dist_sum  : best_d_ff;
      for (int c = 0; c < 3; c++) begin
         best_c_in[c] = take ? s2_e_ff[c] : best_c_ff[c];
      end
   end

   // Output register
   always_comb begin
      rsp_in = rsp_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_vld_in            = 1'b1;
         rsp_in.best_index     = nps_pkg::INDEX_W'(best_idx_ff);
         rsp_in.match_red      = best_c_ff[0];
         rsp_in.match_green    = best_c_ff[1];
         rsp_in.match_blue     = best_c_ff[2];
         rsp_in.match_distance = best_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         max_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         max_ff     <= max_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      addr_ff     <= addr_in;
      s1_last_ff  <= s1_last_in;
      s1_idx_ff   <= s1_idx_in;
      s2_last_ff  <= s2_last_in;
      s2_idx_ff   <= s2_idx_in;
      best_idx_ff <= best_idx_in;
      best_d_ff   <= best_d_in;
      rsp_ff      <= rsp_in;
      for (int c = 0; c < 3; c++) begin
         s2_sq_ff[c]  <= s2_sq_in[c];
         s2_e_ff[c]   <= s2_e_in[c];
         best_c_ff[c] <= best_c_in[c];
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/nps_checker.sv */
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks on the nearest palette colour search core.
// ----------------------------------------------------------------------------
module nps_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input nps_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input nps_pkg::rsp_type rsp_data
);

   // A stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req transaction changed while stalled");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   // Reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Distance never exceeds the largest three-component square sum
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.match_distance <= nps_pkg::MAX_DIST)
      else $error("match_distance out of range");

   // No result transaction right after reset
   a_no_accept_in_reset: assert property (@(posedge clock)
      reset |=> !(rsp_valid && rsp_ready))
      else $error("rsp transaction straight after reset");

endmodule

bind nearest_palette_color_search_core nps_checker u_nps_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest palette colour search core: palette
// loads and colour queries are driven in random bursts, every query is
// searched again in the bench and each result transaction is checked field
// by field against the oldest outstanding search.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ENTRIES         = 256;
   localparam int SIX_BIT_CEILING = 63;      // peak component at or below: 6-bit palette
   localparam int COMP_MAX        = 255;
   localparam int TOTAL_ITEMS     = 1850;
   localparam int HOLD_OFF_AFTER  = 50;      // results seen before the long rsp hold-off
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int WATCHDOG_LIMIT  = 20000;   // idle cycles, well above hold-off + one query
   localparam int TAIL_CYCLES     = 400;     // > one full palette walk

   typedef enum logic [1:0] {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   // one queued request; hold_for_drain parks it until no result is outstanding
   typedef struct packed {
      logic             hold_for_drain;
      nps_pkg::req_type data;
   } stim_item_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   nps_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   nps_pkg::rsp_type rsp_data;

   // stimulus
   stim_item_type pending_items[$];
   int            plan_red[ENTRIES];
   int            plan_green[ENTRIES];
   int            plan_blue[ENTRIES];
   int            plan_peak;
   int            burst_left = 1;
   int            gap_left   = 0;
   logic          stim_done  = 1'b0;

   // bench copy of the palette and the peak-component tracker
   nps_pkg::comp_type pal_red[ENTRIES];
   nps_pkg::comp_type pal_green[ENTRIES];
   nps_pkg::comp_type pal_blue[ENTRIES];
   nps_pkg::comp_type peak_comp = '0;
   nps_pkg::rsp_type  nearest_due[$];
   logic              drained      = 1'b1;
   int                results_seen = 0;
   int                fail_count   = 0;

   // receiver pattern
   rx_mode_type rx_mode      = RX_STEADY;
   int          rx_mode_left = 0;
   int          hold_left    = 0;
   logic        hold_done    = 1'b0;

   int          idle_cycles  = 0;

   nearest_palette_color_search_core #(
      .PALETTE_ENTRIES(ENTRIES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Bench search: squared distance on the 8-bit scale, strict less-than so
   // the lowest index keeps a tie. A 6-bit palette is read shifted up by 2.
   // ------------------------------------------------------------------------
   function automatic int comp_sq(input nps_pkg::comp_type a,
                                  input nps_pkg::comp_type b);
      int diff;
      diff = int'(a) - int'(b);
      return diff * diff;
   endfunction

   function automatic nps_pkg::rsp_type search_nearest(input nps_pkg::req_type query);
      nps_pkg::rsp_type  best;
      logic              six_bit;
      nps_pkg::comp_type eff_r, eff_g, eff_b;
      int                dist_sum;
      best    = '0;
      six_bit = (peak_comp <= SIX_BIT_CEILING);
      for (int i = 0; i < ENTRIES; i++) begin
         eff_r = six_bit ? {pal_red[i][nps_pkg::COMP_W-3:0], 2'b00}   : pal_red[i];
         eff_g = six_bit ? {pal_green[i][nps_pkg::COMP_W-3:0], 2'b00} : pal_green[i];
         eff_b = six_bit ? {pal_blue[i][nps_pkg::COMP_W-3:0], 2'b00}  : pal_blue[i];
         dist_sum = comp_sq(eff_r, query.red) + comp_sq(eff_g, query.green)
                  + comp_sq(eff_b, query.blue);
         if (i == 0 || dist_sum < int'(best.match_distance)) begin
            best.best_index     = nps_pkg::INDEX_W'(i);
            best.match_red      = eff_r;
            best.match_green    = eff_g;
            best.match_blue     = eff_b;
            best.match_distance = nps_pkg::DIST_W'(dist_sum);
         end
      end
      return best;
   endfunction

   // a load to slot 0 restarts the peak tracker, other loads only raise it
   task automatic store_entry(input nps_pkg::req_type load);
      nps_pkg::comp_type top;
      top = (load.entry_index == 0) ? '0 : peak_comp;
      if (load.red > top)   top = load.red;
      if (load.green > top) top = load.green;
      if (load.blue > top)  top = load.blue;
      pal_red[load.entry_index]   = load.red;
      pal_green[load.entry_index] = load.green;
      pal_blue[load.entry_index]  = load.blue;
      peak_comp = top;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building. The plan_* shadow follows the palette as queued, so
   // queries can aim at exact and near matches of what will be loaded.
   // ------------------------------------------------------------------------
   task automatic push_load(input int idx, input int r, input int g, input int b);
      stim_item_type item;
      int            top;
      item                  = '0;
      item.data.action      = nps_pkg::ACT_LOAD;
      item.data.entry_index = nps_pkg::INDEX_W'(idx);
      item.data.red         = nps_pkg::COMP_W'(r);
      item.data.green       = nps_pkg::COMP_W'(g);
      item.data.blue        = nps_pkg::COMP_W'(b);
      pending_items.push_back(item);
      plan_red[idx]   = r;
      plan_green[idx] = g;
      plan_blue[idx]  = b;
      top = (r > g) ? r : g;
      top = (b > top) ? b : top;
      plan_peak = (idx == 0 || top > plan_peak) ? top : plan_peak;
   endtask

   task automatic push_query(input int r, input int g, input int b, input logic park);
      stim_item_type item;
      item                  = '0;
      item.hold_for_drain   = park;
      item.data.action      = nps_pkg::ACT_QUERY;
      item.data.entry_index = nps_pkg::INDEX_W'($urandom);   // don't-care, toggled anyway
      item.data.red         = nps_pkg::COMP_W'(r);
      item.data.green       = nps_pkg::COMP_W'(g);
      item.data.blue        = nps_pkg::COMP_W'(b);
      pending_items.push_back(item);
   endtask

   function automatic int pick_comp(input logic low_range);
      int roll;
      roll = $urandom_range(0, 9);
      if (low_range)
         return (roll == 0) ? 0 : (roll == 1) ? SIX_BIT_CEILING
                                              : $urandom_range(0, SIX_BIT_CEILING);
      return (roll == 0) ? 0 : (roll == 1) ? COMP_MAX : $urandom_range(0, COMP_MAX);
   endfunction

   function automatic int plan_effective(input int v);
      return (plan_peak <= SIX_BIT_CEILING) ? ((v << 2) & COMP_MAX) : v;
   endfunction

   function automatic int nudge(input int v);
      int n;
      n = v + $urandom_range(0, 6) - 3;
      return (n < 0) ? 0 : (n > COMP_MAX) ? COMP_MAX : n;
   endfunction

   task automatic push_random_query();
      int   style, idx;
      logic park;
      style = $urandom_range(0, 9);
      idx   = $urandom_range(0, ENTRIES - 1);
      park  = ($urandom_range(0, 149) == 0);
      if (style < 4)
         push_query($urandom_range(0, COMP_MAX), $urandom_range(0, COMP_MAX),
                    $urandom_range(0, COMP_MAX), park);
      else if (style < 7)
         push_query(plan_effective(plan_red[idx]), plan_effective(plan_green[idx]),
                    plan_effective(plan_blue[idx]), park);
      else if (style < 9)
         push_query(nudge(plan_effective(plan_red[idx])),
                    nudge(plan_effective(plan_green[idx])),
                    nudge(plan_effective(plan_blue[idx])), park);
      else
         push_query($urandom_range(0, 1) * COMP_MAX, $urandom_range(0, 1) * COMP_MAX,
                    $urandom_range(0, 1) * COMP_MAX, park);
   endtask

   task automatic build_stimulus();
      int  kind, count;
      logic lr;
      // every slot written before the first query
      push_load(0, COMP_MAX, 0, 128);
      for (int i = 1; i < ENTRIES; i++)
         push_load(i, pick_comp(1'b0), pick_comp(1'b0), pick_comp(1'b0));

      // directed: extremes, exact hit, tie, tracker restarts in and out of 6-bit
      push_query(0, 0, 0, 1'b0);
      push_query(COMP_MAX, COMP_MAX, COMP_MAX, 1'b0);
      push_query(plan_red[17], plan_green[17], plan_blue[17], 1'b0);
      push_load(90, 77, 11, 222);
      push_load(30, 77, 11, 222);
      push_query(77, 11, 222, 1'b1);                  // tie, parked until drained
      push_load(0, SIX_BIT_CEILING, SIX_BIT_CEILING, SIX_BIT_CEILING);
      push_query(252, 252, 252, 1'b0);                // old large entries wrap
      push_query(1, 128, 254, 1'b0);
      push_load(5, SIX_BIT_CEILING + 1, 1, 2);        // one component leaves 6-bit
      push_query(SIX_BIT_CEILING + 1, 1, 2, 1'b0);
      push_load(0, 0, 0, 0);
      push_load(9, SIX_BIT_CEILING, 0, SIX_BIT_CEILING);
      push_query(COMP_MAX, 0, COMP_MAX, 1'b0);

      // all-black palette: largest distance, and a tie over every slot
      for (int i = 0; i < ENTRIES; i++)
         push_load(i, 0, 0, 0);
      push_query(COMP_MAX, COMP_MAX, COMP_MAX, 1'b0);
      push_query(0, 0, 0, 1'b0);
      push_query(128, 1, 254, 1'b0);

      while (pending_items.size() < TOTAL_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // a few loads then queries over the updated palette
            lr    = ($urandom_range(0, 3) == 0);
            count = $urandom_range(1, 6);
            repeat (count)
               push_load($urandom_range(0, ENTRIES - 1), pick_comp(lr), pick_comp(lr),
                         pick_comp(lr));
            count = $urandom_range(1, 3);
            repeat (count) push_random_query();
         end else if (kind < 78) begin
            // restart on slot 0 with low values: 6-bit palette
            push_load(0, pick_comp(1'b1), pick_comp(1'b1), pick_comp(1'b1));
            count = $urandom_range(2, 12);
            repeat (count)
               push_load($urandom_range(1, ENTRIES - 1), pick_comp(1'b1), pick_comp(1'b1),
                         pick_comp(1'b1));
            count = $urandom_range(1, 3);
            repeat (count) push_random_query();
         end else if (kind < 90) begin
            // broken: 6-bit restart spoilt by one large component
            push_load(0, pick_comp(1'b1), pick_comp(1'b1), pick_comp(1'b1));
            count = $urandom_range(0, 3);
            repeat (count)
               push_load($urandom_range(1, ENTRIES - 1), pick_comp(1'b1), pick_comp(1'b1),
                         pick_comp(1'b1));
            push_load($urandom_range(0, ENTRIES - 1), pick_comp(1'b1),
                      $urandom_range(SIX_BIT_CEILING + 1, COMP_MAX), pick_comp(1'b1));
            push_random_query();
         end else if ($urandom_range(0, 1) == 0) begin
            // noise
            push_load($urandom_range(0, ENTRIES - 1), $urandom_range(0, COMP_MAX),
                      $urandom_range(0, COMP_MAX), $urandom_range(0, COMP_MAX));
         end else begin
            push_query($urandom_range(0, COMP_MAX), $urandom_range(0, COMP_MAX),
                       $urandom_range(0, COMP_MAX), 1'b0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps. A parked item
   // waits with valid low until the scoreboard reports nothing outstanding;
   // requiring valid low as well covers a query accepted on the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : feed_driver
      stim_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // transaction still on offer, hold payload
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pending_items.size() != 0 &&
                   (!pending_items[0].hold_for_drain || (drained && !req_valid))) begin
         nxt       = pending_items.pop_front();
         req_valid <= 1'b1;
         req_data  <= nxt.data;
         if (burst_left <= 1) begin
            if ($urandom_range(0, 7) == 0) begin
               burst_left <= $urandom_range(100, 300);   // long stretch, no idling
               gap_left   <= 0;
            end else begin
               burst_left <= $urandom_range(1, 30);
               gap_left   <= $urandom_range(0, 15);
            end
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
         if (pending_items.size() == 0)
            stim_done <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: its own mode pattern, plus one long hold-off once some
   // results have come, so the core backs up and stalls the request side.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_type'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(32, 400);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Scoreboard: result side first so a result never meets the search of a
   // query accepted on the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      nps_pkg::rsp_type want;
      if (reset) begin
         peak_comp = '0;
         nearest_due.delete();
         drained <= 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (nearest_due.size() == 0) begin
               $error("unexpected result transaction: best_index %0d", rsp_data.best_index);
               fail_count++;
            end else begin
               want = nearest_due.pop_front();
               check_field("best_index", want.best_index, rsp_data.best_index);
               check_field("match_red", want.match_red, rsp_data.match_red);
               check_field("match_green", want.match_green, rsp_data.match_green);
               check_field("match_blue", want.match_blue, rsp_data.match_blue);
               check_field("match_distance", want.match_distance, rsp_data.match_distance);
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.action == nps_pkg::ACT_QUERY)
               nearest_due.push_back(search_nearest(req_data));
            else
               store_entry(req_data);
         end
         drained <= (nearest_due.size() == 0);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (!stim_done) @(posedge clock);
      while (!drained) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (nearest_due.size() != 0) begin
         $error("%0d results never arrived", nearest_due.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
src/nps_pkg.sv
src/nps_ram.sv
src/nps_front.sv
src/nps_queue.sv
src/nps_back.sv
src/nearest_palette_color_search_core.sv
src/nps_checker.sv
dv/tb_top.sv
